[rtl/ptst_pkg.sv]
// Package for the polling timer slot table.
// Holds sizes, command and status codes, conversion constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptst_pkg;

  // Number of timer slots (1 to 16).
  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int TIME_W = 16;
  localparam int GOV_W  = 6;
  localparam int ALU_W  = 32;

  // Command codes.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD_ID  = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  // One time base overflow period is 2000 ms; one tick is 30517 ns.
  localparam logic [ALU_W-1:0] PERIOD_MS = 32'd2000;

  // duration / 2000 equals (duration >> 4) / 125, taken as
  // ((duration >> 4) * 4195) >> 19, which is exact for every 16-bit duration.
  localparam int          OV_PRE_SHIFT = 4;
  localparam logic [12:0] OV_RECIP     = 13'd4195;
  localparam int          OV_SHIFT     = 19;
  localparam int          OV_PROD_W    = 25;

  // remainder * 1000000 / 30517 is taken as (remainder * 2199064915) >> 26,
  // which is exact for every remainder below 2000.
  localparam logic [31:0] TK_RECIP  = 32'd2199064915;
  localparam int          TK_SHIFT  = 26;
  localparam int          REM_W     = 11;
  localparam int          TK_PROD_W = 42;

  typedef struct packed {
    logic [TIME_W-1:0] begin_overflows;
    logic [TIME_W-1:0] begin_ticks;
    logic [GOV_W-1:0]  goal_overflows;
    logic [TIME_W-1:0] goal_ticks;
  } ptst_entry_t;

  typedef struct packed {
    logic              set;
    logic [SLOT_W-1:0] set_idx;
    logic              clr;
    logic [SLOT_W-1:0] clr_idx;
  } ptst_slot_cmd_t;

endpackage

`default_nettype wire

[rtl/ptst_alu.sv]
// Shared subtract and compare unit of the polling timer slot table.
// Depends on ptst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptst_alu
  import ptst_pkg::*;
(
  input  wire logic [ALU_W-1:0] a,
  input  wire logic [ALU_W-1:0] b,
  output      logic [ALU_W-1:0] diff,
  output      logic             ge
);

  always_comb begin
    diff = a - b;
    ge   = (a >= b);
  end

endmodule

`default_nettype wire

[rtl/ptst_slots.sv]
// Slot storage of the polling timer slot table: busy flags and timer entries.
// Depends on ptst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptst_slots
  import ptst_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ptst_slot_cmd_t slot_cmd,
  input  wire ptst_entry_t    wr_entry,
  input  wire logic [SLOT_W-1:0] rd_idx,
  output      ptst_entry_t    rd_entry,
  output      logic [SLOTS-1:0] busy_vec
);

  ptst_entry_t      entries_r [SLOTS];
  logic [SLOTS-1:0] busy_r;
  logic [SLOTS-1:0] busy_nxt;

  always_comb begin
    busy_nxt = busy_r;
    if (slot_cmd.set) begin
      busy_nxt[slot_cmd.set_idx] = 1'b1;
    end
    if (slot_cmd.clr) begin
      busy_nxt[slot_cmd.clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Entries are only read while their busy flag is set, so they need no reset.
  always_ff @(posedge clk) begin
    if (slot_cmd.set) begin
      entries_r[slot_cmd.set_idx] <= wr_entry;
    end
  end

  assign rd_entry = entries_r[rd_idx];
  assign busy_vec = busy_r;

endmodule

`default_nettype wire

[rtl/polling_timer_slot_table.sv]
// Top level of the polling timer slot table: command sequencer and result port.
// Depends on ptst_pkg, ptst_alu and ptst_slots.
//
// Usage: a request is offered on the in_ ports and taken at a rising edge where
// start is high and busy is low. Start claims the lowest free slot, check tests
// a slot for expiry against the time base on in_now_overflows/in_now_ticks, and
// end frees a slot. Every request gives exactly one result, shown on the out_
// ports for a single cycle with out_valid high; the receiver cannot stall it.
// Steps from the accepting edge to the strobe cycle:
//   start with a free slot: a reciprocal multiply for duration / 2000, the
//   remainder subtract on the shared unit, and a reciprocal multiply for the
//   tick goal;
//   check on a busy slot: up to five compare steps;
//   every other request: the result is registered at the accepting edge.
// Busy stays high until the result is registered, so one request is in flight
// at a time; a new request may be taken in the cycle its predecessor's strobe
// is shown. Reset clears all busy flags, both error counters and the strobe,
// and holds busy high while rst_n is low.
`timescale 1ns / 1ps
`default_nettype none

module polling_timer_slot_table
  import ptst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_duration_ms,
  input  wire logic [3:0]  in_slot,
  input  wire logic [15:0] in_now_overflows,
  input  wire logic [15:0] in_now_ticks,
  output      logic        out_valid,
  output      logic [3:0]  out_handle,
  output      logic [1:0]  out_status,
  output      logic        out_expired,
  output      logic [15:0] out_bad_id_total,
  output      logic [15:0] out_idle_check_total
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;  // waiting for a request
  localparam logic [3:0] S_OV   = 4'd1;  // duration / 2000 by reciprocal multiply
  localparam logic [3:0] S_REM  = 4'd2;  // duration - 2000 * overflows
  localparam logic [3:0] S_TK   = 4'd3;  // remainder * 1000000 / 30517
  localparam logic [3:0] S_CDOV = 4'd4;  // overflow difference
  localparam logic [3:0] S_CDTK = 4'd5;  // tick difference and wrap test
  localparam logic [3:0] S_CADJ = 4'd6;  // borrow one overflow after a tick wrap
  localparam logic [3:0] S_CGOV = 4'd7;  // compare against goal overflows
  localparam logic [3:0] S_CGTK = 4'd8;  // compare against goal ticks

  logic [3:0]        state_r, state_nxt;
  logic [ALU_W-1:0]  rem_r, rem_nxt;
  logic [GOV_W-1:0]  gov_r, gov_nxt;
  logic [15:0]       dov_r, dov_nxt;
  logic [15:0]       dtk_r, dtk_nxt;
  logic [SLOT_W-1:0] sel_r, sel_nxt;
  logic [15:0]       nov_r, nov_nxt;
  logic [15:0]       ntk_r, ntk_nxt;
  logic [15:0]       bad_cnt_r, bad_cnt_nxt;
  logic [15:0]       idle_cnt_r, idle_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_handle_r, out_handle_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_expired_r, out_expired_nxt;

  logic [ALU_W-1:0]     alu_a, alu_b, alu_diff;
  logic                 alu_ge;
  logic [OV_PROD_W-1:0] ov_prod;
  logic [TK_PROD_W-1:0] tk_prod;

  ptst_slot_cmd_t    slot_cmd;
  ptst_entry_t       wr_entry;
  ptst_entry_t       rd_entry;
  logic [SLOTS-1:0]  busy_vec;

  logic              accept;
  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  logic              slot_bad;
  logic [SLOT_W-1:0] in_idx;

  ptst_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  ptst_slots u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .slot_cmd (slot_cmd),
    .wr_entry (wr_entry),
    .rd_idx   (sel_r),
    .rd_entry (rd_entry),
    .busy_vec (busy_vec)
  );

  assign busy   = (state_r != S_IDLE) || !rst_n;
  assign accept = start && !busy;

  // Lowest free slot; the loop runs from the top so the lowest index wins.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_vec[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign slot_bad = ({1'b0, in_slot} >= 5'(SLOTS));
  assign in_idx   = in_slot[SLOT_W-1:0];

  // Reciprocal products for the duration conversion. The first works on the
  // duration shifted right by four, the second on the remainder below 2000, so it fits in 11 bits.
  assign ov_prod = OV_PROD_W'(rem_r[15:OV_PRE_SHIFT]) * OV_PROD_W'(OV_RECIP);
  assign tk_prod = TK_PROD_W'(rem_r[REM_W-1:0]) * TK_PROD_W'(TK_RECIP);

  always_comb begin
    state_nxt       = state_r;
    rem_nxt         = rem_r;
    gov_nxt         = gov_r;
    dov_nxt         = dov_r;
    dtk_nxt         = dtk_r;
    sel_nxt         = sel_r;
    nov_nxt         = nov_r;
    ntk_nxt         = ntk_r;
    bad_cnt_nxt     = bad_cnt_r;
    idle_cnt_nxt    = idle_cnt_r;
    out_valid_nxt   = 1'b0;
    out_handle_nxt  = out_handle_r;
    out_status_nxt  = out_status_r;
    out_expired_nxt = out_expired_r;
    slot_cmd        = '0;
    alu_a           = rem_r;
    alu_b           = '0;
    wr_entry.begin_overflows = nov_r;
    wr_entry.begin_ticks     = ntk_r;
    wr_entry.goal_overflows  = gov_r;
    wr_entry.goal_ticks      = tk_prod[TK_SHIFT +: TIME_W];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          nov_nxt         = in_now_overflows;
          ntk_nxt         = in_now_ticks;
          out_handle_nxt  = '0;
          out_expired_nxt = 1'b0;
          out_status_nxt  = ST_OK;
          unique case (in_cmd)
            CMD_START: begin
              if (free_any) begin
                sel_nxt   = free_idx;
                rem_nxt   = {16'd0, in_duration_ms};
                state_nxt = S_OV;
              end else begin
                out_status_nxt = ST_NO_FREE;
                out_valid_nxt  = 1'b1;
              end
            end
            CMD_CHECK: begin
              if (slot_bad) begin
                bad_cnt_nxt    = bad_cnt_r + 16'd1;
                out_status_nxt = ST_BAD_ID;
                out_valid_nxt  = 1'b1;
              end else if (!busy_vec[in_idx]) begin
                idle_cnt_nxt   = idle_cnt_r + 16'd1;
                out_status_nxt = ST_IDLE;
                out_valid_nxt  = 1'b1;
              end else begin
                sel_nxt   = in_idx;
                state_nxt = S_CDOV;
              end
            end
            CMD_END: begin
              // An id beyond the table is ignored; freeing an idle slot is harmless.
              if (!slot_bad) begin
                slot_cmd.clr     = 1'b1;
                slot_cmd.clr_idx = in_idx;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_OV: begin
        gov_nxt   = ov_prod[OV_SHIFT +: GOV_W];
        state_nxt = S_REM;
      end

      S_REM: begin
        alu_a     = rem_r;
        alu_b     = {26'd0, gov_r} * PERIOD_MS;
        rem_nxt   = alu_diff;
        state_nxt = S_TK;
      end

      S_TK: begin
        slot_cmd.set     = 1'b1;
        slot_cmd.set_idx = sel_r;
        out_handle_nxt   = 4'(sel_r);
        out_status_nxt   = ST_OK;
        out_valid_nxt    = 1'b1;
        state_nxt        = S_IDLE;
      end

      S_CDOV: begin
        alu_a     = {16'd0, nov_r};
        alu_b     = {16'd0, rd_entry.begin_overflows};
        dov_nxt   = alu_diff[15:0];
        state_nxt = S_CDTK;
      end

      S_CDTK: begin
        alu_a   = {16'd0, ntk_r};
        alu_b   = {16'd0, rd_entry.begin_ticks};
        dtk_nxt = alu_diff[15:0];
        if (alu_ge) begin
          state_nxt = S_CGOV;
        end else if (dov_r == 16'd0) begin
          // The ticks wrapped within the same overflow count: not yet expired.
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CADJ;
        end
      end

      S_CADJ: begin
        alu_a     = {16'd0, dov_r};
        alu_b     = 32'd1;
        dov_nxt   = alu_diff[15:0];
        state_nxt = S_CGOV;
      end

      S_CGOV: begin
        alu_a = {16'd0, dov_r};
        alu_b = {26'd0, rd_entry.goal_overflows};
        if (!alu_ge) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (alu_diff != '0) begin
          slot_cmd.clr     = 1'b1;
          slot_cmd.clr_idx = sel_r;
          out_expired_nxt  = 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          state_nxt = S_CGTK;
        end
      end

      S_CGTK: begin
        alu_a = {16'd0, dtk_r};
        alu_b = {16'd0, rd_entry.goal_ticks};
        if (alu_ge) begin
          slot_cmd.clr     = 1'b1;
          slot_cmd.clr_idx = sel_r;
          out_expired_nxt  = 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bad_cnt_r   <= '0;
      idle_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bad_cnt_r   <= bad_cnt_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    gov_r         <= gov_nxt;
    dov_r         <= dov_nxt;
    dtk_r         <= dtk_nxt;
    sel_r         <= sel_nxt;
    nov_r         <= nov_nxt;
    ntk_r         <= ntk_nxt;
    out_handle_r  <= out_handle_nxt;
    out_status_r  <= out_status_nxt;
    out_expired_r <= out_expired_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_handle           = out_handle_r;
  assign out_status           = out_status_r;
  assign out_expired          = out_expired_r;
  assign out_bad_id_total     = bad_cnt_r;
  assign out_idle_check_total = idle_cnt_r;

endmodule

`default_nettype wire

[rtl/ptst_checker.sv]
// Port-level checker for the polling timer slot table, bound to the top level.
// Depends on ptst_pkg and polling_timer_slot_table.
`timescale 1ns / 1ps
`default_nettype none

module ptst_checker
  import ptst_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_cmd,
  input wire logic [3:0]  in_slot,
  input wire logic        out_valid,
  input wire logic [3:0]  out_handle,
  input wire logic [1:0]  out_status,
  input wire logic        out_expired,
  input wire logic [15:0] out_bad_id_total
);

  // Reset leaves the block with no result pending, and idle once reset is released.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && (!busy || !rst_n))
    else $error("block not quiet after reset");

  // An end request gives a plain ok result in the next cycle.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_END
      |=> out_valid && out_status == ST_OK && out_handle == 4'd0 && !out_expired)
    else $error("end request gave a wrong result");

  // A check on an id beyond the table bumps the bad id total by one.
  a_bad_id_count: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == CMD_CHECK && {1'b0, in_slot} >= 5'(SLOTS)
      |=> out_valid && out_status == ST_BAD_ID
          && out_bad_id_total == 16'($past(out_bad_id_total) + 16'd1))
    else $error("bad id check miscounted");

  // Failed requests never claim a handle or report expiry.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_handle == 4'd0 && !out_expired)
    else $error("error result carries a handle or expiry");

endmodule

bind polling_timer_slot_table ptst_checker u_ptst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_cmd           (in_cmd),
  .in_slot          (in_slot),
  .out_valid        (out_valid),
  .out_handle       (out_handle),
  .out_status       (out_status),
  .out_expired      (out_expired),
  .out_bad_id_total (out_bad_id_total)
);

`default_nettype wire
